FILE: src/cbq_pkg.sv
// shared constants for the circular byte queue with search
// field widths, operation codes and status codes; no dependencies
`default_nettype none

package cbq_pkg;

   localparam int CBQ_DEPTH = 64;

   localparam int DATA_W = 8;
   localparam int MODE_W = 3;
   localparam int STAT_W = 2;
   localparam int POS_W  = 6;
   localparam int CNT_W  = 7;

   localparam int CAP_RESET = 64;

   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 8;
   localparam int RSP_TDATA_W = 32;

   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam mode_type MODE_ENQ    = 3'd0;
   localparam mode_type MODE_DEQ    = 3'd1;
   localparam mode_type MODE_PEEK   = 3'd2;
   localparam mode_type MODE_SEARCH = 3'd3;
   localparam mode_type MODE_CLEAR  = 3'd4;

   localparam status_type STAT_OK       = 2'd0;
   localparam status_type STAT_FULL     = 2'd1;
   localparam status_type STAT_EMPTY    = 2'd2;
   localparam status_type STAT_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

FILE: src/cbq_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no package dependencies
`default_nettype none

module cbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/cbq_wrap.sv
// shared modular adder: (base + offset) wrapped at the capacity
// depends on cbq_pkg; assumes base < modulus and offset <= modulus
`default_nettype none

module cbq_wrap (
   input  wire logic [cbq_pkg::CNT_W-1:0] base,
   input  wire logic [cbq_pkg::CNT_W-1:0] offset,
   input  wire logic [cbq_pkg::CNT_W-1:0] modulus,
   output logic      [cbq_pkg::CNT_W-1:0] sum
);

   import cbq_pkg::*;

   logic [CNT_W:0] raw;
   logic [CNT_W:0] mod_ext;

   assign raw     = {1'b0, base} + {1'b0, offset};
   assign mod_ext = {1'b0, modulus};

   // one compare and subtract is enough since raw stays below twice the modulus
   always_comb begin
      if (raw >= mod_ext) begin
         sum = CNT_W'(raw - mod_ext);
      end else begin
         sum = CNT_W'(raw);
      end
   end

endmodule

`default_nettype wire

FILE: src/circular_byte_queue_with_search.sv
// timing: enqueue, clear, unused codes and empty dequeue/peek/search give a result in the cycle
// after the transaction; dequeue and peek pass through a read state (registered store read);
// search runs a scan state, one entry compared per cycle, until a match or the last entry.
// throughput: one request at a time, set by the single store read port and scan loop.
// reset: head and occupancy cleared, capacity 64 (or DEPTH if smaller); store contents
// are left as they are, no clearing pass. a capacity write also empties the queue.
`default_nettype none

module circular_byte_queue_with_search #(
   parameter int DEPTH = cbq_pkg::CBQ_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: tuser = mode[2:0], zero fill; tdata = data_in[7:0]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [cbq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [cbq_pkg::REQ_TUSER_W-1:0] req_tuser,
   // response tdata: status[1:0], data_out[9:2], position[15:10],
   // occupancy[22:16], is_empty[23], is_full[24], zero fill
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [cbq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // capacity register write
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [cbq_pkg::CNT_W-1:0]       csr_data
);

   import cbq_pkg::*;

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CAP_MAX = (DEPTH < 127) ? DEPTH : 127;
   localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;
   localparam logic [CNT_W-1:0] CAP_LIM  = CNT_W'(CAP_MAX);
   localparam logic [CNT_W-1:0] CAP_INIT = CNT_W'(CAP_RST);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [CNT_W-1:0]  chk_idx_ff, chk_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic [CNT_W-1:0]  out_occ_ff, out_occ_in;
   logic              out_empty_ff, out_empty_in;
   logic              out_full_ff, out_full_in;
   logic              out_load;

   logic              req_accept;
   logic              csr_accept;
   mode_type          req_mode;
   logic [DATA_W-1:0] req_byte;

   logic [CNT_W-1:0]  wrap_offset;
   logic [CNT_W-1:0]  wrap_sum;
   logic [CNT_W-1:0]  cap_eff;

   logic              wr_en;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              scan_issue;

   assign req_mode   = req_tuser[MODE_W-1:0];
   assign req_byte   = req_tdata[DATA_W-1:0];
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid;

   // out-of-range capacity folds into 1..min(DEPTH, 127)
   always_comb begin
      if (csr_data == '0) begin
         cap_eff = CNT_ONE;
      end else if (csr_data > CAP_LIM) begin
         cap_eff = CAP_LIM;
      end else begin
         cap_eff = csr_data;
      end
   end

   always_comb begin
      if (state_ff == ST_SCAN) begin
         wrap_offset = scan_ff;
      end else if (req_mode == MODE_ENQ) begin
         wrap_offset = count_ff;
      end else begin
         wrap_offset = CNT_ONE;
      end
   end

   cbq_wrap u_wrap (
      .base    (head_ff),
      .offset  (wrap_offset),
      .modulus (cap_ff),
      .sum     (wrap_sum)
   );

   assign scan_issue = scan_ff < count_ff;
   assign rd_addr    = (state_ff == ST_SCAN) ? IDX_W'(wrap_sum) : IDX_W'(head_ff);

   cbq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(wrap_sum)),
      .wr_data (req_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      key_in        = key_ff;
      scan_in       = scan_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = scan_ff;
      out_load      = 1'b0;
      out_status_in = STAT_OK;
      out_data_in   = '0;
      out_pos_in    = '0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_mode)
                  MODE_ENQ: begin
                     out_load = 1'b1;
                     if (count_ff >= cap_ff) begin
                        out_status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_ONE;
                     end
                  end
                  MODE_DEQ, MODE_PEEK: begin
                     if (count_ff == '0) begin
                        out_load      = 1'b1;
                        out_status_in = STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_READ;
                        if (req_mode == MODE_DEQ) begin
                           head_in  = wrap_sum;
                           count_in = count_ff - CNT_ONE;
                        end
                     end
                  end
                  MODE_SEARCH: begin
                     if (count_ff == '0) begin
                        out_load      = 1'b1;
                        out_status_in = STAT_NOTFOUND;
                     end else begin
                        key_in   = req_byte;
                        scan_in  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_CLEAR: begin
                     out_load = 1'b1;
                     head_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            out_load    = 1'b1;
            out_data_in = rd_data;
            state_in    = ST_IDLE;
         end
         ST_SCAN: begin
            // read entry scan_ff while comparing the one read last cycle
            if (scan_issue) begin
               rd_en        = 1'b1;
               scan_in      = scan_ff + CNT_ONE;
               chk_valid_in = 1'b1;
            end
            if (chk_valid_ff && (rd_data == key_ff)) begin
               out_load     = 1'b1;
               out_pos_in   = chk_idx_ff[POS_W-1:0];
               chk_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end else if (chk_valid_ff && (chk_idx_ff == count_ff - CNT_ONE)) begin
               out_load      = 1'b1;
               out_status_in = STAT_NOTFOUND;
               chk_valid_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capacity write empties the queue
      if (csr_accept) begin
         cap_in   = cap_eff;
         head_in  = '0;
         count_in = '0;
      end

      out_occ_in   = count_in;
      out_empty_in = (count_in == '0);
      out_full_in  = (count_in == cap_ff);

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_INIT;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      if (out_load) begin
         out_status_ff <= out_status_in;
         out_data_ff   <= out_data_in;
         out_pos_ff    <= out_pos_in;
         out_occ_ff    <= out_occ_in;
         out_empty_ff  <= out_empty_in;
         out_full_ff   <= out_full_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, out_full_ff, out_empty_ff, out_occ_ff, out_pos_ff,
                        out_data_ff, out_status_ff};

endmodule

`default_nettype wire

FILE: tb/tb_circular_byte_queue_with_search.sv
// self-checking testbench for circular_byte_queue_with_search
// depends on cbq_pkg and the queue rtl; a ring model predicts all but add_chk replies
`timescale 1ns / 100ps

module tb_circular_byte_queue_with_search;
   import cbq_pkg::*;

   localparam mode_type MODE_RSVD5 = 3'd5;
   localparam mode_type MODE_RSVD6 = 3'd6;
   localparam mode_type MODE_RSVD7 = 3'd7;
   localparam int IDLE_LIMIT  = 1000;
   localparam int TAIL_CYCLES = 80;
   localparam int PHASES      = 10;

   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   data_out;
      logic [POS_W-1:0]    position;
      logic [CNT_W-1:0]    occupancy;
      logic                is_empty;
      logic                is_full;
   } reply_type;

   typedef struct {
      bit                  is_cfg;
      logic [CNT_W-1:0]    cap;
      mode_type            mode;
      logic [DATA_W-1:0]   data;
      bit                  typed;
      reply_type           want;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // data_in[7:0]
   logic [REQ_TUSER_W-1:0] req_tuser = '0;   // mode[2:0], zero fill
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // status[1:0], data_out[9:2], position[15:10], occupancy[22:16],
   // is_empty[23], is_full[24], zero fill
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CNT_W-1:0]       csr_data = '0;

   // ring model state
   logic [DATA_W-1:0]      ring_mem [CBQ_DEPTH];
   int                     ring_head = 0;
   int                     ring_count = 0;
   logic [CNT_W-1:0]       cap_reg = CAP_RESET;

   reply_type              ring_replies [$];
   dir_row_type            dir_rows [$];
   int                     err_count = 0;
   int                     req_count = 0;
   int                     rsp_count = 0;
   int                     cfg_count = 0;
   int                     stat_seen [4] = '{0, 0, 0, 0};
   bit                     quiet_tx = 1'b0;
   bit                     quiet_rx = 1'b0;
   int                     rx_stall = 0;
   int                     idle_cycles = 0;

   circular_byte_queue_with_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // capacity as the queue applies it: zero acts as one, oversize as the depth
   function automatic int ring_span();
      if (cap_reg == 0) return 1;
      if (cap_reg > CBQ_DEPTH) return CBQ_DEPTH;
      return int'(cap_reg);
   endfunction

   function automatic reply_type ring_step(mode_type m, logic [DATA_W-1:0] d);
      reply_type r;
      int        span;
      bit        hit;
      span     = ring_span();
      r        = '0;
      r.status = STAT_OK;
      hit      = 1'b0;
      case (m)
         MODE_ENQ: begin
            if (ring_count >= span) r.status = STAT_FULL;
            else begin
               ring_mem[(ring_head + ring_count) % span] = d;
               ring_count++;
            end
         end
         MODE_DEQ: begin
            if (ring_count == 0) r.status = STAT_EMPTY;
            else begin
               r.data_out = ring_mem[ring_head];
               ring_head  = (ring_head + 1) % span;
               ring_count--;
            end
         end
         MODE_PEEK: begin
            if (ring_count == 0) r.status = STAT_EMPTY;
            else r.data_out = ring_mem[ring_head];
         end
         MODE_SEARCH: begin
            r.status = STAT_NOTFOUND;
            for (int i = 0; i < ring_count; i++) begin
               if (!hit && ring_mem[(ring_head + i) % span] == d) begin
                  hit        = 1'b1;
                  r.status   = STAT_OK;
                  r.position = POS_W'(i);
               end
            end
         end
         MODE_CLEAR: begin
            ring_head  = 0;
            ring_count = 0;
         end
         default: ;
      endcase
      r.occupancy = CNT_W'(ring_count);
      r.is_empty  = (ring_count == 0);
      r.is_full   = (ring_count == span);
      return r;
   endfunction

   task automatic add_op(mode_type m, logic [DATA_W-1:0] d);
      dir_row_type row;
      row = '{is_cfg: 1'b0, cap: '0, mode: m, data: d, typed: 1'b0, want: '0};
      dir_rows.push_back(row);
   endtask

   task automatic add_chk(mode_type m, logic [DATA_W-1:0] d, status_type st, int occ,
                          bit emp, bit full);
      dir_row_type row;
      row = '{is_cfg: 1'b0, cap: '0, mode: m, data: d, typed: 1'b1, want: '0};
      row.want.status    = st;
      row.want.occupancy = CNT_W'(occ);
      row.want.is_empty  = emp;
      row.want.is_full   = full;
      dir_rows.push_back(row);
   endtask

   task automatic add_cfg(logic [CNT_W-1:0] v);
      dir_row_type row;
      row = '{is_cfg: 1'b1, cap: v, mode: MODE_ENQ, data: '0, typed: 1'b0, want: '0};
      dir_rows.push_back(row);
   endtask

   task automatic send_req(mode_type m, logic [DATA_W-1:0] d, bit typed, reply_type want);
      int        gap;
      reply_type predicted;
      gap = quiet_tx ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= REQ_TUSER_W'(m);
      do @(posedge clock); while (!req_tready);
      predicted = ring_step(m, d);
      ring_replies.push_back(typed ? want : predicted);
      req_count++;
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ring_replies.size() != 0);
   endtask

   // a capacity write also empties the queue
   task automatic write_capacity(logic [CNT_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      cap_reg    = v;
      ring_head  = 0;
      ring_count = 0;
      cfg_count++;
   endtask

   task automatic report_mismatch(string field, int unsigned want, int unsigned got);
      $display("mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
               rsp_count, field, want, got);
      err_count++;
   endtask

   // response side: check each transaction, then draw the stall before the next one
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      int        n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_stall   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got.status    = rsp_tdata[1:0];
         got.data_out  = rsp_tdata[9:2];
         got.position  = rsp_tdata[15:10];
         got.occupancy = rsp_tdata[22:16];
         got.is_empty  = rsp_tdata[23];
         got.is_full   = rsp_tdata[24];
         if (ring_replies.size() == 0) begin
            report_mismatch("response with nothing pending", 0, rsp_tdata);
         end else begin
            want = ring_replies.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", want.status, got.status);
            if (got.data_out !== want.data_out)
               report_mismatch("data_out", want.data_out, got.data_out);
            if (got.position !== want.position)
               report_mismatch("position", want.position, got.position);
            if (got.occupancy !== want.occupancy)
               report_mismatch("occupancy", want.occupancy, got.occupancy);
            if (got.is_empty !== want.is_empty)
               report_mismatch("is_empty", want.is_empty, got.is_empty);
            if (got.is_full !== want.is_full)
               report_mismatch("is_full", want.is_full, got.is_full);
         end
         stat_seen[got.status]++;
         rsp_count++;
         n = quiet_rx ? 0 : $urandom_range(0, 8);
         rsp_tready <= (n == 0);
         rx_stall   <= n;
      end else if (!rsp_tready) begin
         if (rx_stall <= 1) rsp_tready <= 1'b1;
         rx_stall <= rx_stall - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("FAIL circular_byte_queue_with_search");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [CNT_W-1:0]  phase_caps [PHASES];
      reply_type         none;
      mode_type          m;
      logic [DATA_W-1:0] d;
      int                span;
      int                draw;
      int                items;
      bit                draining;

      none = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty queue at reset capacity
      add_chk(MODE_DEQ,    8'h00, STAT_EMPTY,    0, 1'b1, 1'b0);
      add_chk(MODE_PEEK,   8'h00, STAT_EMPTY,    0, 1'b1, 1'b0);
      add_chk(MODE_SEARCH, 8'h00, STAT_NOTFOUND, 0, 1'b1, 1'b0);
      add_chk(MODE_RSVD5,  8'h00, STAT_OK,       0, 1'b1, 1'b0);
      add_chk(MODE_ENQ,    8'h00, STAT_OK,       1, 1'b0, 1'b0);
      add_chk(MODE_ENQ,    8'hff, STAT_OK,       2, 1'b0, 1'b0);
      add_op(MODE_PEEK,   8'h00);
      add_op(MODE_SEARCH, 8'hff);
      add_op(MODE_SEARCH, 8'h5a);
      add_op(MODE_DEQ,    8'h00);
      add_op(MODE_RSVD7,  8'hff);
      add_chk(MODE_CLEAR,  8'h00, STAT_OK,       0, 1'b1, 1'b0);
      // single-entry queue
      add_cfg(7'd1);
      add_chk(MODE_ENQ,    8'ha5, STAT_OK,       1, 1'b0, 1'b1);
      add_chk(MODE_ENQ,    8'h3c, STAT_FULL,     1, 1'b0, 1'b1);
      add_op(MODE_DEQ,    8'h00);
      // zero capacity behaves as one entry
      add_cfg(7'd0);
      add_chk(MODE_ENQ,    8'h81, STAT_OK,       1, 1'b0, 1'b1);
      add_chk(MODE_ENQ,    8'h7e, STAT_FULL,     1, 1'b0, 1'b1);
      add_op(MODE_RSVD6,  8'h00);
      // oversize capacity clamps to the depth
      add_cfg(7'd127);
      add_op(MODE_ENQ,    8'h11);
      add_op(MODE_SEARCH, 8'h11);
      // two entries with tail wrap
      add_cfg(7'd2);
      add_op(MODE_ENQ,    8'h01);
      add_op(MODE_ENQ,    8'h02);
      add_op(MODE_DEQ,    8'h00);
      add_op(MODE_ENQ,    8'h03);
      add_op(MODE_SEARCH, 8'h03);

      foreach (dir_rows[k]) begin
         if (dir_rows[k].is_cfg) begin
            drain_replies();
            write_capacity(dir_rows[k].cap);
         end else begin
            send_req(dir_rows[k].mode, dir_rows[k].data, dir_rows[k].typed,
                     dir_rows[k].want);
         end
      end

      phase_caps    = '{7'd64, 7'd1, 7'd0, 7'd2, 7'd127, 7'd3, 7'd65, 7'd17, 7'd8, 7'd64};
      phase_caps[9] = CNT_W'($urandom_range(1, CBQ_DEPTH));

      for (int p = 0; p < PHASES; p++) begin
         drain_replies();
         write_capacity(phase_caps[p]);
         quiet_tx = ($urandom_range(0, 3) == 0);
         quiet_rx = ($urandom_range(0, 3) == 0);
         span     = ring_span();
         items    = (span > 16) ? 80 : 25;
         draining = 1'b0;
         for (int k = 0; k < items; k++) begin
            // fill until full, then drain until empty, with noise in between
            if (ring_count == span && $urandom_range(0, 3) == 0) draining = 1'b1;
            else if (ring_count == 0) draining = 1'b0;
            draw = $urandom_range(0, 99);
            if (!draining) begin
               if (draw < 80)      m = MODE_ENQ;
               else if (draw < 85) m = MODE_DEQ;
               else if (draw < 94) m = MODE_SEARCH;
               else if (draw < 97) m = MODE_PEEK;
               else                m = mode_type'($urandom_range(MODE_RSVD5, MODE_RSVD7));
            end else begin
               if (draw < 15)      m = MODE_ENQ;
               else if (draw < 68) m = MODE_DEQ;
               else if (draw < 83) m = MODE_SEARCH;
               else if (draw < 93) m = MODE_PEEK;
               else if (draw < 97) m = MODE_CLEAR;
               else                m = mode_type'($urandom_range(MODE_RSVD5, MODE_RSVD7));
            end
            // a few small values make repeated bytes, so first-match order matters
            d = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 3))
                                            : DATA_W'($urandom_range(0, 255));
            if (m == MODE_SEARCH && ring_count > 0 && $urandom_range(0, 9) < 7)
               d = ring_mem[(ring_head + $urandom_range(0, ring_count - 1)) % span];
            send_req(m, d, 1'b0, none);
            if ($urandom_range(0, 49) == 0) drain_replies();
         end
      end

      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (ring_replies.size() != 0)
         report_mismatch("responses still pending", 0, ring_replies.size());

      $display("ran %0d requests and %0d responses across %0d capacity writes",
               req_count, rsp_count, cfg_count);
      $display("status mix: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches",
               stat_seen[STAT_OK], stat_seen[STAT_FULL], stat_seen[STAT_EMPTY],
               stat_seen[STAT_NOTFOUND], err_count);
      if (err_count == 0) begin
         $display("PASS circular_byte_queue_with_search");
      end else begin
         $display("FAIL circular_byte_queue_with_search");
      end
      $finish;
   end

endmodule
